### rtl/kmer_hamming_one_counter_assert.svh
// Assertion macros used by the kmer Hamming-one counter top level.
`ifndef KMER_HAMMING_ONE_COUNTER_ASSERT_SVH
`define KMER_HAMMING_ONE_COUNTER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled while rst is high.
`define KHOC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("khoc assertion failed");
// Next-cycle implication, sampled on clk and disabled while rst is high.
`define KHOC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("khoc assertion failed");
`else
`define KHOC_ASSERT_IMP(lbl, ante, cons)
`define KHOC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/khoc_pkg.sv
// Types, constants and helper functions of the kmer Hamming-one counter.
package khoc_pkg;

  localparam int MAX_K       = 16;
  localparam int COUNT_WIDTH = 32;
  localparam int K_W         = 5;
  localparam int COL_W       = 4;
  localparam int OUT_W       = 32;
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_PTR_W   = 2;
  localparam int OUT_CNT_W   = 3;

  typedef enum logic [1:0] {
    KIND_BASE  = 2'd0,
    KIND_BOUND = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  localparam logic [1:0] REG_SEED_LENGTH = 2'd0;
  localparam logic [1:0] REG_SEED_MASKS  = 2'd1;
  localparam logic [1:0] REG_TWO_STRANDS = 2'd2;
  localparam logic [1:0] REG_PAL_TWICE   = 2'd3;

  typedef logic [1:0]             base_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  localparam count_t COUNT_MAX = '1;
  localparam logic [OUT_CNT_W-1:0] OUT_FULL = OUT_CNT_W'(OUT_DEPTH);

  typedef struct packed {
    logic [K_W-1:0] seed_length;
    logic [63:0]    seed_masks;
    logic           two_strands;
    logic           palindromes_twice;
  } cfg_t;

  // Increment request for one column: one row on each strand.
  typedef struct packed {
    logic  fw_inc;
    base_t fw_row;
    logic  rv_inc;
    base_t rv_row;
  } col_inc_t;

  typedef struct packed {
    col_inc_t [MAX_K-1:0] col;
    logic [1:0]           seed_add;
    logic [1:0]           total_add;
  } judge_res_t;

  // Complement of an IUPAC mask: A<->T and C<->G swap bit positions.
  function automatic logic [3:0] comp_mask(input logic [3:0] m);
    return {m[0], m[1], m[2], m[3]};
  endfunction

  function automatic logic [3:0] base_onehot(input base_t b);
    return 4'b0001 << b;
  endfunction

  function automatic logic [3:0] col_mask(input logic [63:0] masks,
                                          input logic [COL_W-1:0] col);
    return masks[{col, 2'b00} +: 4];
  endfunction

  // Seed length in use: zero acts as one, anything above MAX_K as MAX_K.
  function automatic logic [K_W-1:0] eff_len(input logic [K_W-1:0] sl);
    if (sl == '0) begin
      return K_W'(1);
    end else if (sl > K_W'(MAX_K)) begin
      return K_W'(MAX_K);
    end else begin
      return sl;
    end
  endfunction

  // Saturating add of zero, one or two.
  function automatic count_t sat_add(input count_t c, input logic [1:0] a);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, c} + {{(COUNT_WIDTH-1){1'b0}}, a};
    return s[COUNT_WIDTH] ? COUNT_MAX : s[COUNT_WIDTH-1:0];
  endfunction

endpackage

### rtl/khoc_cell.sv
// One column cell: a window base tap and the four counters of its column.
module khoc_cell
  import khoc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     shift_en,
  input  base_t    base_in,
  output base_t    base_q,
  input  col_inc_t inc,
  input  logic     clear,
  input  base_t    rd_row,
  output count_t   rd_count
);

  count_t cnt [4];
  count_t cnt_next [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      cnt_next[r] = sat_add(cnt[r],
                            {1'b0, inc.fw_inc && (inc.fw_row == base_t'(r))} +
                            {1'b0, inc.rv_inc && (inc.rv_row == base_t'(r))});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_q <= '0;
    end else if (shift_en) begin
      base_q <= base_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int r = 0; r < 4; r++) begin
        cnt[r] <= '0;
      end
    end else begin
      for (int r = 0; r < 4; r++) begin
        cnt[r] <= cnt_next[r];
      end
    end
  end

  assign rd_count = cnt[rd_row];

endmodule

### rtl/khoc_judge.sv
// Window judge: compares both strands against the seed and forms increments.
module khoc_judge
  import khoc_pkg::*;
(
  input  cfg_t                cfg,
  input  base_t [MAX_K-1:0]   win,
  input  logic                en,
  output judge_res_t          res
);

  logic [K_W-1:0]   k;
  logic [COL_W-1:0] klast;
  logic [3:0]       m [MAX_K];
  base_t            fw_b [MAX_K];
  base_t            rv_b [MAX_K];
  logic [MAX_K-1:0] active, pair_ok, fw_mis, rv_mis, fw_cell, rv_cell, pal_rv;
  logic             seed_pal, fw_nm0, fw_nm1, rv_nm0, rv_nm1, rv_seed_ok;
  logic             seed_fw, seed_rv, tot_fw, tot_rv;

  always_comb begin
    logic [COL_W-1:0] p;
    logic             except_ok;
    k     = eff_len(cfg.seed_length);
    klast = COL_W'(k - K_W'(1));
    for (int j = 0; j < MAX_K; j++) begin
      m[j] = cfg.seed_masks[4*j +: 4];
    end
    for (int j = 0; j < MAX_K; j++) begin
      p          = klast - COL_W'(j);
      active[j]  = K_W'(j) < k;
      fw_b[j]    = win[p];
      rv_b[j]    = ~win[j];
      pair_ok[j] = !active[j] || (m[j] == comp_mask(m[p]));
      fw_mis[j]  = active[j] && !m[j][fw_b[j]];
      rv_mis[j]  = active[j] && !m[j][rv_b[j]];
    end
    seed_pal = &pair_ok;
    fw_nm0   = fw_mis == '0;
    rv_nm0   = rv_mis == '0;
    fw_nm1   = !fw_nm0 && ((fw_mis & (fw_mis - 1'b1)) == '0);
    rv_nm1   = !rv_nm0 && ((rv_mis & (rv_mis - 1'b1)) == '0);

    // A seed with column j replaced by a literal base is a palindrome when
    // every other column pair mirrors and the literal mirrors its partner.
    // The middle column of an odd length can never mirror a single base.
    for (int j = 0; j < MAX_K; j++) begin
      p         = klast - COL_W'(j);
      except_ok = 1'b1;
      for (int i = 0; i < MAX_K; i++) begin
        except_ok = except_ok &&
                    (pair_ok[i] || (COL_W'(i) == COL_W'(j)) || (COL_W'(i) == p));
      end
      pal_rv[j] = (p != COL_W'(j)) && except_ok &&
                  (base_onehot(rv_b[j]) == comp_mask(m[p]));
      fw_cell[j] = active[j] &&
                   ((fw_nm0 && (m[j] != base_onehot(fw_b[j]))) ||
                    (fw_nm1 && fw_mis[j]));
      rv_cell[j] = active[j] && cfg.two_strands &&
                   (cfg.palindromes_twice || !pal_rv[j]) &&
                   ((rv_nm0 && (m[j] != base_onehot(rv_b[j]))) ||
                    (rv_nm1 && rv_mis[j]));
    end

    rv_seed_ok = cfg.two_strands && (cfg.palindromes_twice || !seed_pal);
    seed_fw    = en && fw_nm0;
    seed_rv    = en && rv_nm0 && rv_seed_ok;
    tot_fw     = en && (fw_nm0 || fw_nm1);
    tot_rv     = en && (rv_nm0 ? rv_seed_ok : (rv_nm1 && (|rv_cell)));

    res.seed_add  = {1'b0, seed_fw} + {1'b0, seed_rv};
    res.total_add = {1'b0, tot_fw} + {1'b0, tot_rv};
    for (int j = 0; j < MAX_K; j++) begin
      res.col[j].fw_inc = en && fw_cell[j];
      res.col[j].fw_row = fw_b[j];
      res.col[j].rv_inc = en && rv_cell[j];
      res.col[j].rv_row = rv_b[j];
    end
  end

endmodule

### rtl/khoc_fifo.sv
// Small result queue between the counter stage and the output stream.
module khoc_fifo
  import khoc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [3*OUT_W-1:0]   push_data,
  input  logic                 pop,
  output logic                 out_valid,
  output logic [3*OUT_W-1:0]   out_data,
  output logic [OUT_CNT_W-1:0] count
);

  logic [3*OUT_W-1:0]   mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    end
  end

  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];

endmodule

### rtl/kmer_hamming_one_counter.sv
// Top level of the kmer Hamming-one counter with its stream and config ports.
//
// The block takes one word per clock on the s_ side while s_tready is high:
// a base, a sequence boundary, a cell read or a counter clear, chosen by
// s_tuser. Bases shift into a row of sixteen column cells; each full window
// of the configured seed length is judged on the forward strand and on its
// reverse complement with all columns compared in parallel, so a base word
// is taken every such cycle. Work runs in three steps: the accept edge
// shifts the window, the judge stage forms the per-column increments, and
// the counter stage updates the cells and serves reads, pushing each read's
// result into a four-word output queue; m_tvalid rises in the cycle after
// the push. s_tready drops only while queued results plus reads still in
// flight fill all four queue places. Counters sit in flip-flops cleared by
// reset, so no clearing pass follows reset.
`include "kmer_hamming_one_counter_assert.svh"
module kmer_hamming_one_counter
  import khoc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // base [1:0], column [5:2], zero [7:6]
  input  logic [1:0]  s_tuser,   // kind [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata    // cell_count [31:0], seed hits [63:32],
                                 // total hits [95:64]
);

  cfg_t cfg;

  logic             in_acc;
  kind_t            in_kind;
  base_t            in_base;
  logic [COL_W-1:0] in_col;
  logic [K_W-1:0]   k;

  logic [K_W-1:0] window_fill, window_fill_next;
  base_t [MAX_K-1:0] win;

  // Judge stage registers.
  logic             p1_valid;
  kind_t            p1_kind;
  base_t            p1_base;
  logic [COL_W-1:0] p1_col;
  logic             p1_judge;
  judge_res_t       judge_res;

  // Counter stage registers.
  logic             p2_valid;
  kind_t            p2_kind;
  base_t            p2_base;
  logic [COL_W-1:0] p2_col;
  judge_res_t       p2_res;

  count_t           seed_hits, total_hits;
  count_t           rd_count [MAX_K];
  count_t           cell_val;
  logic             p2_clear, push;
  logic [OUT_CNT_W-1:0] fifo_count, reserved;

  assign in_kind = kind_t'(s_tuser);
  assign in_base = s_tdata[1:0];
  assign in_col  = s_tdata[5:2];
  assign in_acc  = s_tvalid && s_tready;
  assign k       = eff_len(cfg.seed_length);

  // Configuration registers; the user must write them only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seed_length       <= K_W'(8);
      cfg.seed_masks        <= '1;
      cfg.two_strands       <= 1'b1;
      cfg.palindromes_twice <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEED_LENGTH: cfg.seed_length       <= cfg_data[K_W-1:0];
        REG_SEED_MASKS:  cfg.seed_masks        <= cfg_data;
        REG_TWO_STRANDS: cfg.two_strands       <= cfg_data[0];
        REG_PAL_TWICE:   cfg.palindromes_twice <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The fill count saturates at the window depth and a boundary empties it,
  // so no window ever spans two sequences.
  always_comb begin
    window_fill_next = window_fill;
    if (in_acc) begin
      case (in_kind)
        KIND_BASE: begin
          if (window_fill < K_W'(MAX_K)) begin
            window_fill_next = window_fill + K_W'(1);
          end
        end
        KIND_BOUND: window_fill_next = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill <= '0;
    end else begin
      window_fill <= window_fill_next;
    end
  end

  // The pipeline never stalls: the output queue reserves room for every read
  // before it is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= in_acc;
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_kind  <= in_kind;
    p1_base  <= in_base;
    p1_col   <= in_col;
    p1_judge <= in_acc && (in_kind == KIND_BASE) && (window_fill_next >= k);
    p2_kind  <= p1_kind;
    p2_base  <= p1_base;
    p2_col   <= p1_col;
    p2_res   <= judge_res;
  end

  khoc_judge u_judge (
    .cfg (cfg),
    .win (win),
    .en  (p1_valid && p1_judge),
    .res (judge_res)
  );

  // Row of column cells; the window base taps shift from cell to cell.
  assign p2_clear = p2_valid && (p2_kind == KIND_CLEAR);

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    khoc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift_en (in_acc && (in_kind == KIND_BASE)),
      .base_in  ((i == 0) ? in_base : win[(i == 0) ? 0 : i-1]),
      .base_q   (win[i]),
      .inc      (p2_valid ? p2_res.col[i] : '0),
      .clear    (p2_clear),
      .rd_row   (p2_base),
      .rd_count (rd_count[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst || p2_clear) begin
      seed_hits  <= '0;
      total_hits <= '0;
    end else if (p2_valid) begin
      seed_hits  <= sat_add(seed_hits, p2_res.seed_add);
      total_hits <= sat_add(total_hits, p2_res.total_add);
    end
  end

  // A column beyond the seed reads as zero; a cell whose column mask is the
  // literal base itself is never counted and reads as the seed count.
  always_comb begin
    cell_val = '0;
    if (K_W'(p2_col) < k) begin
      if (col_mask(cfg.seed_masks, p2_col) == base_onehot(p2_base)) begin
        cell_val = seed_hits;
      end else begin
        cell_val = rd_count[p2_col];
      end
    end
  end

  assign push = p2_valid && (p2_kind == KIND_READ);

  khoc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({OUT_W'(total_hits), OUT_W'(seed_hits), OUT_W'(cell_val)}),
    .pop       (m_tvalid && m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .count     (fifo_count)
  );

  // Queue places taken or promised to reads still in the pipeline.
  assign reserved = fifo_count +
                    OUT_CNT_W'(p1_valid && (p1_kind == KIND_READ)) +
                    OUT_CNT_W'(p2_valid && (p2_kind == KIND_READ));
  assign s_tready = reserved < OUT_FULL;

  `KHOC_ASSERT_IMP(a_no_overflow, push, fifo_count < OUT_FULL)
  `KHOC_ASSERT_IMP(a_credit_bound, 1'b1, reserved <= OUT_FULL)
  `KHOC_ASSERT_IMP(a_total_ge_seed, 1'b1, total_hits >= seed_hits)
  `KHOC_ASSERT_NEXT(a_seed_monotone, !p2_clear, seed_hits >= $past(seed_hits))

endmodule

### test/kmer_hamming_one_counter_tb.sv
// Testbench: streams bases, boundaries, reads and clears and checks every read reply.
module kmer_hamming_one_counter_tb
  import khoc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // The run should never go this many cycles with no word, reply or register
  // write accepted. The longest quiet stretch in a correct run is the output
  // hold plus the pipeline drain, so this leaves ample margin.
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 8;

  localparam base_t NT_A = 2'd0;
  localparam base_t NT_G = 2'd2;
  localparam base_t NT_T = 2'd3;

  typedef enum {SEED_MIXED, SEED_MIRROR, SEED_LITERAL} seed_style_t;

  typedef struct {
    count_t cell_cnt;
    count_t seed;
    count_t total;
  } read_reply_t;

  // Software tally of the seed neighborhood: it keeps its own window, register
  // copies and counters, and queues the reply each accepted read should get.
  class neighbor_tally;
    logic [4:0]       seed_len;
    logic [63:0]      masks;
    bit               both_strands;
    bit               pal_twice;
    logic [15:0][1:0] window;
    int unsigned      fill;
    count_t           cells [64];
    count_t           seed_tally;
    count_t           total_tally;
    read_reply_t      replies_due [$];
    int unsigned      errors;
    int unsigned      replies_checked;

    function new();
      seed_len = 5'd8;
      masks = '1;
      both_strands = 1'b1;
      pal_twice = 1'b0;
      window = '0;
      fill = 0;
      errors = 0;
      replies_checked = 0;
      clear_counts();
    endfunction

    function void clear_counts();
      foreach (cells[i]) cells[i] = '0;
      seed_tally = '0;
      total_tally = '0;
    endfunction

    function void set_config(logic [4:0] len, logic [63:0] m, bit two, bit pal);
      seed_len = len;
      masks = m;
      both_strands = two;
      pal_twice = pal;
    endfunction

    // Window length in use: zero behaves as one, anything past 16 as 16.
    function int span();
      if (seed_len == 5'd0) return 1;
      if (seed_len > 5'd16) return 16;
      return int'(seed_len);
    endfunction

    function logic [3:0] col_mask_of(int j);
      return masks[4*j +: 4];
    endfunction

    // Seed column mask, or the literal base where one column is substituted.
    function logic [3:0] variant_mask(int j, int alt_col, base_t alt_base);
      return (j == alt_col) ? (4'b0001 << alt_base) : col_mask_of(j);
    endfunction

    // A pattern is its own reverse complement when each column equals the
    // complement of its mirror column.
    function bit is_mirror(int k, int alt_col, base_t alt_base);
      int i;
      logic [3:0] a, b;
      for (i = 0; i < k; i++) begin
        a = variant_mask(i, alt_col, alt_base);
        b = variant_mask(k - 1 - i, alt_col, alt_base);
        if (a != {b[0], b[1], b[2], b[3]}) return 1'b0;
      end
      return 1'b1;
    endfunction

    function bit strand_counts(bit rev, int k, int alt_col, base_t alt_base);
      if (!rev) return 1'b1;
      if (!both_strands) return 1'b0;
      return pal_twice || !is_mirror(k, alt_col, alt_base);
    endfunction

    function count_t bumped(count_t c);
      return (&c) ? c : c + 1'b1;
    endfunction

    function void score_window(logic [15:0][1:0] w, int k, bit rev);
      int j, misses, miss_col;
      logic [3:0] m;
      misses = 0;
      miss_col = 0;
      for (j = 0; j < k; j++) begin
        m = col_mask_of(j);
        if (!m[w[j]]) begin
          misses++;
          miss_col = j;
        end
      end
      if (misses == 0) begin
        if (strand_counts(rev, k, -1, 2'd0)) begin
          seed_tally = bumped(seed_tally);
          total_tally = bumped(total_tally);
        end
        // Columns whose mask is exactly the window base are never counted.
        for (j = 0; j < k; j++) begin
          if (col_mask_of(j) != (4'b0001 << w[j]) && strand_counts(rev, k, j, w[j]))
            cells[{w[j], 4'(j)}] = bumped(cells[{w[j], 4'(j)}]);
        end
      end else if (misses == 1 && strand_counts(rev, k, miss_col, w[miss_col])) begin
        cells[{w[miss_col], 4'(miss_col)}] = bumped(cells[{w[miss_col], 4'(miss_col)}]);
        total_tally = bumped(total_tally);
      end
    endfunction

    // Called for every accepted input word, in order of acceptance.
    function void take_word(kind_t kind, base_t b, logic [3:0] col);
      logic [15:0][1:0] fw, rv;
      read_reply_t r;
      int k, i;
      k = span();
      fw = '0;
      rv = '0;
      case (kind)
        KIND_BASE: begin
          window = {window[14:0], b};
          if (fill < 16) fill++;
          if (fill >= k) begin
            for (i = 0; i < k; i++) begin
              fw[i] = window[k - 1 - i];
              rv[i] = ~window[i];
            end
            score_window(fw, k, 1'b0);
            score_window(rv, k, 1'b1);
          end
        end
        KIND_BOUND: fill = 0;
        KIND_CLEAR: clear_counts();
        default: begin
          r.cell_cnt = '0;
          if (col < k)
            r.cell_cnt = (col_mask_of(col) == (4'b0001 << b)) ? seed_tally : cells[{b, col}];
          r.seed = seed_tally;
          r.total = total_tally;
          replies_due.insert(replies_due.size(), r);
        end
      endcase
    endfunction

    // Called for every accepted output word.
    function void check_reply(logic [95:0] d);
      read_reply_t want;
      if (replies_due.size() == 0) begin
        $error("read reply %h arrived with no read outstanding", d);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      replies_checked++;
      if (d[31:0] !== want.cell_cnt) begin
        $error("cell_count: expected %0d, got %0d", want.cell_cnt, d[31:0]);
        errors++;
      end
      if (d[63:32] !== want.seed) begin
        $error("seed hits: expected %0d, got %0d", want.seed, d[63:32]);
        errors++;
      end
      if (d[95:64] !== want.total) begin
        $error("total hits: expected %0d, got %0d", want.total, d[95:64]);
        errors++;
      end
    endfunction

    function int unsigned due();
      return replies_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // base [1:0], column [5:2], zero [7:6]
  logic [1:0]  s_tuser = '0;    // kind [1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;         // cell_count [31:0], seed hits [63:32],
                                // total hits [95:64]

  neighbor_tally tally;
  int unsigned   words_sent = 0;
  int unsigned   burst_left = 0;
  int unsigned   settings_run = 0;
  int unsigned   quiet_cycles = 0;
  bit            hold_off_req = 1'b0;

  kmer_hamming_one_counter i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #6 clk = ~clk;

  // Both handshakes are observed here, on the values that were stable before
  // the edge, so the tally never depends on process order within a step.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        tally.take_word(kind_t'(s_tuser), s_tdata[1:0], s_tdata[5:2]);
      end
      if (m_tvalid && m_tready) begin
        tally.check_reply(m_tdata);
      end
    end
  end

  // Watchdog: a long stretch with nothing accepted means the block hung.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: switches between always ready, light stalls, heavy stalls and
  // alternate-cycle stalls in spans of random length. When asked, it holds
  // m_tready low for a long stretch so the output queue fills and the block
  // has to push back on its input.
  initial begin : receiver
    int unsigned span_left, style, n;
    span_left = 0;
    style = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end
      if (span_left == 0) begin
        style = $urandom_range(0, 3);
        span_left = $urandom_range(1, 60);
      end
      span_left--;
      case (style)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ~m_tready;
      endcase
    end
  end

  // Offers one word and returns at the edge where it is taken. The sender
  // works in bursts; between bursts it may drop s_tvalid for a random gap.
  // The valid is left high after a word so back-to-back words never toggle it.
  task automatic send_word(kind_t kind, base_t b, logic [3:0] col);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {2'b00, col, b};
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // Writes all four registers; only called once the block has gone idle.
  task automatic configure(logic [4:0] len, logic [63:0] m, bit two, bit pal);
    write_reg(REG_SEED_LENGTH, 64'(len));
    write_reg(REG_SEED_MASKS, m);
    write_reg(REG_TWO_STRANDS, 64'(two));
    write_reg(REG_PAL_TWICE, 64'(pal));
    cfg_we <= 1'b0;
    tally.set_config(len, m, two, pal);
    settings_run++;
  endtask

  // Waits for every outstanding reply, then lets base words still in the
  // judge and counter stages settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tally.due() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  // Random base that fits (or misses) mask m; any base if that is impossible.
  function automatic base_t pick_base(logic [3:0] m, bit fit);
    base_t b;
    if ((fit && m == 4'h0) || (!fit && m == 4'hF)) return base_t'($urandom_range(0, 3));
    do b = base_t'($urandom_range(0, 3)); while (m[b] != fit);
    return b;
  endfunction

  // Random seed masks. Mirrored seeds equal their own reverse complement over
  // the first k columns; literal seeds hold one base per column.
  function automatic logic [63:0] make_seed(int k, seed_style_t style);
    logic [63:0] s;
    logic [3:0] m;
    int j;
    int unsigned c;
    for (j = 0; j < 16; j++) begin
      c = $urandom_range(0, 9);
      if (style == SEED_LITERAL || c <= 3) m = 4'b0001 << $urandom_range(0, 3);
      else if (c <= 6) m = (4'b0001 << $urandom_range(0, 3)) | (4'b0001 << $urandom_range(0, 3));
      else if (c <= 8) m = 4'hF;
      else m = 4'($urandom);
      s[4*j +: 4] = m;
    end
    if (style == SEED_MIRROR) begin
      for (j = 0; j < k / 2; j++) begin
        m = s[4*j +: 4];
        s[4*(k-1-j) +: 4] = {m[0], m[1], m[2], m[3]};
      end
      if (k % 2 == 1) begin
        m = 4'($urandom);
        s[4*(k/2) +: 4] = {m[0], m[1], m[1], m[0]};
      end
    end
    return s;
  endfunction

  // Most of the traffic is a fresh window built to match the seed, sometimes
  // with one column spoiled and sometimes sent as its reverse complement so
  // that it hits on the other strand, followed by reads aimed at the cells it
  // should have touched. The rest is random words of any kind.
  task automatic stream_runs(int unsigned n);
    logic [15:0][1:0] p;
    logic [3:0] rd_col;
    int unsigned start, k, j, pick, miss, r;
    bit flip_strand;
    kind_t nk;
    start = words_sent;
    while (words_sent - start < n) begin
      k = tally.span();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 3) != 0) send_word(KIND_BOUND, base_t'($urandom), 4'($urandom));
        miss = ($urandom_range(0, 9) < 4) ? $urandom_range(0, k - 1) : 16;
        for (j = 0; j < 16; j++) p[j] = pick_base(tally.col_mask_of(j), j != miss);
        flip_strand = $urandom_range(0, 1);
        for (j = 0; j < k; j++) begin
          send_word(KIND_BASE, flip_strand ? ~p[k - 1 - j] : p[j], 4'($urandom));
        end
        repeat ($urandom_range(0, 2)) send_word(KIND_BASE, base_t'($urandom), 4'($urandom));
        repeat ($urandom_range(1, 2)) begin
          rd_col = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(0, k - 1)) : 4'($urandom);
          send_word(KIND_READ, $urandom_range(0, 1) ? p[rd_col] : base_t'($urandom), rd_col);
        end
      end else if (pick < 97) begin
        repeat ($urandom_range(1, 5)) begin
          r = $urandom_range(0, 99);
          if (r < 50) nk = KIND_BASE;
          else if (r < 70) nk = KIND_BOUND;
          else if (r < 97) nk = KIND_READ;
          else nk = KIND_CLEAR;
          send_word(nk, base_t'($urandom), 4'($urandom));
        end
      end else begin
        send_word(KIND_CLEAR, base_t'($urandom), 4'($urandom));
        send_word(KIND_READ, base_t'($urandom), 4'($urandom));
      end
    end
  endtask

  // One register setting: write it, optionally squeeze the output side with a
  // long hold while reads keep coming, stream random runs, then go idle.
  task automatic run_setting(logic [4:0] len, logic [63:0] m, bit two, bit pal,
                             bit squeeze);
    configure(len, m, two, pal);
    if (squeeze) begin
      hold_off_req = 1'b1;
      burst_left = 40;
      repeat (24) send_word(KIND_READ, base_t'($urandom), 4'($urandom));
    end
    stream_runs(130);
    drain();
  endtask

  initial begin : stimulus
    int i;
    tally = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: length 8 with every column wildcard, so every full
    // window hits and the all-wildcard seed is its own reverse complement.
    for (i = 0; i < 8; i++) send_word(KIND_BASE, base_t'(i < 4 ? i : 7 - i), 4'd0);
    send_word(KIND_READ, NT_T, 4'd7);
    drain();

    // Literal seed ACGT (column 0 in the low nibble), which is palindromic:
    // the reverse-strand hit must be dropped with palindromes counted once.
    configure(5'd4, 64'h0000_0000_0000_8421, 1'b1, 1'b0);
    for (i = 0; i < 4; i++) send_word(KIND_BASE, base_t'(i), 4'd15);
    send_word(KIND_BOUND, NT_A, 4'd0);
    // ACGG: one mismatch in the last column.
    for (i = 0; i < 4; i++) send_word(KIND_BASE, (i == 3) ? NT_G : base_t'(i), 4'd0);
    send_word(KIND_READ, NT_G, 4'd3);
    // The literal seed base of a column reads back the seed count.
    send_word(KIND_READ, NT_T, 4'd3);
    // A column past the seed length reads zero.
    send_word(KIND_READ, NT_A, 4'd15);
    send_word(KIND_CLEAR, NT_T, 4'd15);
    send_word(KIND_READ, NT_G, 4'd3);
    // A boundary leaves a short window that must not be judged.
    send_word(KIND_BOUND, NT_T, 4'd15);
    send_word(KIND_BASE, NT_T, 4'd15);
    send_word(KIND_READ, NT_A, 4'd0);
    drain();

    run_setting(5'd8, '1, 1'b1, 1'b0, 1'b0);
    run_setting(5'd4, make_seed(4, SEED_MIXED), 1'b1, 1'b0, 1'b0);
    run_setting(5'd16, '1, 1'b1, 1'b1, 1'b0);
    run_setting(5'd1, '0, 1'b1, 1'b1, 1'b0);
    run_setting(5'd0, make_seed(1, SEED_MIXED), 1'b0, 1'b0, 1'b0);
    run_setting(5'd6, make_seed(6, SEED_MIRROR), 1'b1, 1'b0, 1'b1);
    run_setting(5'd6, make_seed(6, SEED_MIRROR), 1'b1, 1'b1, 1'b0);
    run_setting(5'd31, make_seed(16, SEED_MIXED), 1'b1, 1'b1, 1'b0);
    run_setting(5'd8, make_seed(8, SEED_LITERAL), 1'b1, 1'b0, 1'b0);
    run_setting(5'd12, '0, 1'b1, 1'b0, 1'b0);
    run_setting(5'd5, make_seed(5, SEED_MIXED), 1'b0, 1'b1, 1'b0);
    run_setting(5'd3, make_seed(3, SEED_MIRROR), 1'b1, 1'b0, 1'b0);

    $display("Sent %0d words over %0d register settings: seed lengths 0, 1, 16 and 31,",
             words_sent, settings_run);
    $display("both strand modes, mirrored seeds and a long output hold; %0d replies checked.",
             tally.replies_checked);
    if (tally.errors == 0 && tally.due() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/khoc_pkg.sv
rtl/khoc_cell.sv
rtl/khoc_judge.sv
rtl/khoc_fifo.sv
rtl/kmer_hamming_one_counter.sv
test/kmer_hamming_one_counter_tb.sv
